@@ hw/rtl/dwps_pkg.sv @@
// shared constants, codes and controller/datapath types of the path selector
package dwps_pkg;

   localparam int NUM_PATHS = 8;
   localparam int IDX_W     = 3;
   localparam int CNT_W     = 4;
   localparam int DELAY_W   = 24;
   localparam int STEP_W    = 8;
   localparam int SUM_W     = DELAY_W + IDX_W;
   localparam int WORD_W    = 64;
   localparam int HALF_W    = 32;
   localparam int REASON_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = DELAY_W;
   localparam int DIV_CNT_W = 6;

   localparam logic [WORD_W-1:0]  ALL_ONES  = 64'hffff_ffff_ffff_ffff;
   localparam logic [WORD_W-1:0]  XS_MULT   = 64'h2545_f491_4f6c_dd1d;
   localparam logic [DELAY_W-1:0] MAX_DELAY_RST = 24'd100000;
   localparam logic [STEP_W-1:0]  AGE_STEP_RST  = 8'd5;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AGEING_STEP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DELAY   = 2'd2;

   // pick reasons
   localparam logic [REASON_W-1:0] RSN_UNMEASURED = 2'd0;
   localparam logic [REASON_W-1:0] RSN_MAP        = 2'd1;
   localparam logic [REASON_W-1:0] RSN_FALLBACK   = 2'd2;
   localparam logic [REASON_W-1:0] RSN_AGEING     = 2'd3;

   // item kinds
   localparam logic KIND_UPDATE = 1'b0;
   localparam logic KIND_SELECT = 1'b1;

   // shared multiplier operand selects
   localparam logic [2:0] MUL_XLO_KLO = 3'd0;
   localparam logic [2:0] MUL_XLO_KHI = 3'd1;
   localparam logic [2:0] MUL_XHI_KLO = 3'd2;
   localparam logic [2:0] MUL_QLO_D   = 3'd3;
   localparam logic [2:0] MUL_QHI_D   = 3'd4;

   typedef struct packed {
      logic             upd_write;
      logic             scan_step;
      logic             age_step;
      logic             first;
      logic [IDX_W-1:0] idx;
      logic             div_init;
      logic             div_step;
      logic             xs_step;
      logic [2:0]       mul_sel;
      logic             acc_load;
      logic             acc_addhi;
      logic             rnd_load;
      logic             map_step;
   } cmd_type;

   typedef struct packed {
      logic             mode;
      logic             cur_zero;
      logic             map_hit;
      logic [IDX_W-1:0] best_idx;
   } status_type;

endpackage

@@ hw/rtl/dwps_req_if.sv @@
// request channel: valid/ready handshake with one input item
interface dwps_req_if;
   import dwps_pkg::*;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [IDX_W-1:0]   path_index;
   logic [DELAY_W-1:0] sent_timestamp;
   logic [DELAY_W-1:0] now_timestamp;
   logic [CNT_W-1:0]   path_count;

   modport source (output valid, kind, path_index, sent_timestamp, now_timestamp,
                   path_count, input ready);
   modport sink (input valid, kind, path_index, sent_timestamp, now_timestamp,
                 path_count, output ready);
endinterface

@@ hw/rtl/dwps_rsp_if.sv @@
// response channel: valid/ready handshake with one result item
interface dwps_rsp_if;
   import dwps_pkg::*;
   logic                valid;
   logic                ready;
   logic [IDX_W-1:0]    chosen_path;
   logic [REASON_W-1:0] pick_reason;

   modport source (output valid, chosen_path, pick_reason, input ready);
   modport sink (input valid, chosen_path, pick_reason, output ready);
endinterface

@@ hw/rtl/delay_weighted_path_selector_unit.sv @@
// top level of the delay-weighted path selector
// Usage:
// req_chan carries items; kind 0 stores the clamped timestamp difference
// into one path's delay, kind 1 asks for a path and yields one result on
// rsp_chan (chosen_path, pick_reason). An update completes in the cycle of
// its transfer and produces no result.
// Selection, probabilistic mode: the candidate paths are scanned in turn;
// if all are measured, a bit-serial divide of all-ones by the delay sum
// follows, then the generator (one shared 32x32 multiplier), then the map
// entries in turn, and last the result is posted. Ageing mode: the candidates
// are scanned in turn, then the result is posted. One item is worked on at
// a time; req_chan.ready is high when idle. A finished result sits in an
// output register, so the next item is taken while rsp_chan stalls; a
// second result waits until that register frees. Configuration writes via
// csr_* take effect at once; the user must make them only while idle, and
// the block itself does not enforce this. Reset (synchronous) clears all
// delays to unmeasured, zeroes the random word and restores the register
// defaults.
module delay_weighted_path_selector_unit (
   input  logic                           clock,
   input  logic                           reset,
   dwps_req_if.sink                       req_chan,
   dwps_rsp_if.source                     rsp_chan,
   input  logic                           csr_write_en,
   input  logic [dwps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dwps_pkg::CSR_DAT_W-1:0] csr_write_data
);
   import dwps_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing
   dwps_controller u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_kind       (req_chan.kind),
      .req_path_count (req_chan.path_count),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_path       (rsp_chan.chosen_path),
      .rsp_reason     (rsp_chan.pick_reason),
      .cmd            (cmd),
      .status         (status)
   );

   // arithmetic and state
   dwps_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .upd_path       (req_chan.path_index),
      .upd_sent       (req_chan.sent_timestamp),
      .upd_now        (req_chan.now_timestamp),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

@@ hw/rtl/dwps_datapath.sv @@
// datapath: delay file, random word, divider, shared multiplier and map
module dwps_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [dwps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dwps_pkg::CSR_DAT_W-1:0] csr_write_data,
   input  logic [dwps_pkg::IDX_W-1:0]     upd_path,
   input  logic [dwps_pkg::DELAY_W-1:0]   upd_sent,
   input  logic [dwps_pkg::DELAY_W-1:0]   upd_now,
   input  dwps_pkg::cmd_type              cmd,
   output dwps_pkg::status_type           status
);
   import dwps_pkg::*;

   logic [DELAY_W-1:0] delay_ff [NUM_PATHS];
   logic               mode_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [DELAY_W-1:0] maxd_ff;
   logic [WORD_W-1:0]  rnd_ff, x_ff, quot_ff, acc_ff, mul_ff, map_ff;
   logic [SUM_W-1:0]   sum_ff, rem_ff;
   logic [IDX_W-1:0]   best_ff;
   logic [DELAY_W-1:0] bestval_ff;

   logic [DELAY_W-1:0] cur_d, diff, clamped, age_d, cmp_d;
   logic [SUM_W:0]     shifted;
   logic               qbit;
   logic [SUM_W-1:0]   rem_in;
   logic [WORD_W-1:0]  x0, x1, x2, x3;
   logic [HALF_W-1:0]  mul_a, mul_b;
   logic [WORD_W-1:0]  hi_sum, qv, prev, sat_sum, map_in;

   assign cur_d = delay_ff[cmd.idx];

   // measured delay with clamp
   always_comb begin
      diff    = (upd_sent > upd_now) ? upd_sent - upd_now : upd_now - upd_sent;
      clamped = (diff > maxd_ff) ? maxd_ff : diff;
   end

   // aged delay, saturating at zero
   always_comb begin
      age_d = (cur_d > {{(DELAY_W-STEP_W){1'b0}}, step_ff})
            ? cur_d - {{(DELAY_W-STEP_W){1'b0}}, step_ff} : '0;
      cmp_d = cmd.age_step ? age_d : cur_d;
   end

   // one restoring division step of all-ones by the delay sum
   always_comb begin
      shifted = {rem_ff, 1'b1};
      qbit    = (shifted >= {1'b0, sum_ff});
      rem_in  = qbit ? SUM_W'(shifted - {1'b0, sum_ff}) : shifted[SUM_W-1:0];
   end

   // xorshift part of the generator
   always_comb begin
      x0 = (rnd_ff == '0) ? WORD_W'(1) : rnd_ff;
      x1 = x0 ^ (x0 >> 12);
      x2 = x1 ^ (x1 << 25);
      x3 = x2 ^ (x2 >> 27);
   end

   // shared multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         MUL_XLO_KLO: begin mul_a = x_ff[HALF_W-1:0];  mul_b = XS_MULT[HALF_W-1:0]; end
         MUL_XLO_KHI: begin mul_a = x_ff[HALF_W-1:0];  mul_b = XS_MULT[WORD_W-1:HALF_W]; end
         MUL_XHI_KLO: begin mul_a = x_ff[WORD_W-1:HALF_W]; mul_b = XS_MULT[HALF_W-1:0]; end
         MUL_QLO_D:   begin mul_a = quot_ff[HALF_W-1:0];
                            mul_b = {{(HALF_W-DELAY_W){1'b0}}, cur_d}; end
         MUL_QHI_D:   begin mul_a = quot_ff[WORD_W-1:HALF_W];
                            mul_b = {{(HALF_W-DELAY_W){1'b0}}, cur_d}; end
         default:     begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // product assembly and saturating map entry
   always_comb begin
      hi_sum  = acc_ff + {mul_ff[HALF_W-1:0], {HALF_W{1'b0}}};
      qv      = ~hi_sum;
      prev    = cmd.first ? '0 : map_ff;
      sat_sum = qv + prev;
      map_in  = (sat_sum < prev) ? ALL_ONES : sat_sum;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         step_ff <= AGE_STEP_RST;
         maxd_ff <= MAX_DELAY_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_POLICY_MODE: mode_ff <= csr_write_data[0];
            CSR_AGEING_STEP: step_ff <= csr_write_data[STEP_W-1:0];
            CSR_MAX_DELAY:   maxd_ff <= csr_write_data[DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   // delay file and random word
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PATHS; i++) delay_ff[i] <= '0;
         rnd_ff <= '0;
      end else begin
         if (cmd.upd_write) delay_ff[upd_path] <= clamped;
         if (cmd.age_step)  delay_ff[cmd.idx] <= age_d;
         if (cmd.rnd_load)  rnd_ff <= hi_sum;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      mul_ff <= WORD_W'(mul_a * mul_b);
      if (cmd.scan_step || cmd.age_step) begin
         if (cmd.first || cmp_d < bestval_ff) begin
            best_ff    <= cmd.idx;
            bestval_ff <= cmp_d;
         end
      end
      if (cmd.scan_step)
         sum_ff <= cmd.first ? SUM_W'(cur_d) : sum_ff + SUM_W'(cur_d);
      if (cmd.div_init) rem_ff <= '0;
      if (cmd.div_step) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[WORD_W-2:0], qbit};
      end
      if (cmd.xs_step)   x_ff   <= x3;
      if (cmd.acc_load)  acc_ff <= mul_ff;
      if (cmd.acc_addhi) acc_ff <= hi_sum;
      if (cmd.map_step)  map_ff <= map_in;
   end

   always_comb begin
      status.mode     = mode_ff;
      status.cur_zero = (cur_d == '0);
      status.map_hit  = (rnd_ff <= map_in);
      status.best_idx = best_ff;
   end

endmodule

@@ hw/rtl/dwps_controller.sv @@
// controller: sequences scan, divide, generator, map walk and ageing
module dwps_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_kind,
   input  logic [dwps_pkg::CNT_W-1:0]  req_path_count,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [dwps_pkg::IDX_W-1:0]  rsp_path,
   output logic [dwps_pkg::REASON_W-1:0] rsp_reason,
   output dwps_pkg::cmd_type           cmd,
   input  dwps_pkg::status_type        status
);
   import dwps_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_RNG  = 3'd3;
   localparam logic [2:0] S_MAP  = 3'd4;
   localparam logic [2:0] S_AGE  = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                pbest_ff, pbest_in;
   logic [IDX_W-1:0]    pidx_ff, pidx_in;
   logic [REASON_W-1:0] prsn_ff, prsn_in;
   logic                rv_ff, rv_in;
   logic [IDX_W-1:0]    rpath_ff, rpath_in;
   logic [REASON_W-1:0] rrsn_ff, rrsn_in;
   logic [CNT_W-1:0]    n_req;
   logic                last, accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign last      = ({1'b0, idx_ff} + CNT_W'(1)) == n_ff;

   // candidate count limited to one through the path total
   always_comb begin
      if (req_path_count == '0) n_req = CNT_W'(1);
      else if (req_path_count > CNT_W'(NUM_PATHS)) n_req = CNT_W'(NUM_PATHS);
      else n_req = req_path_count;
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      n_in     = n_ff;
      cnt_in   = cnt_ff;
      pbest_in = pbest_ff;
      pidx_in  = pidx_ff;
      prsn_in  = prsn_ff;
      rv_in    = rv_ff && !rsp_ready;
      rpath_in = rpath_ff;
      rrsn_in  = rrsn_ff;
      cmd      = '0;
      cmd.idx  = idx_ff;
      cmd.first = (idx_ff == '0);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_UPDATE) begin
                  cmd.upd_write = 1'b1;
               end else begin
                  n_in     = n_req;
                  idx_in   = '0;
                  state_in = status.mode ? S_AGE : S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.cur_zero) begin
               pbest_in = 1'b0;
               pidx_in  = idx_ff;
               prsn_in  = RSN_UNMEASURED;
               state_in = S_DONE;
            end else if (last) begin
               cmd.div_init = 1'b1;
               cnt_in   = '0;
               state_in = S_DIV;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == '1) begin
               cnt_in   = '0;
               state_in = S_RNG;
            end
         end
         S_RNG: begin
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            case (cnt_ff[2:0])
               3'd0: cmd.xs_step = 1'b1;
               3'd1: cmd.mul_sel = MUL_XLO_KLO;
               3'd2: begin cmd.mul_sel = MUL_XLO_KHI; cmd.acc_load = 1'b1; end
               3'd3: begin cmd.mul_sel = MUL_XHI_KLO; cmd.acc_addhi = 1'b1; end
               default: begin
                  cmd.rnd_load = 1'b1;
                  cnt_in   = '0;
                  idx_in   = '0;
                  state_in = S_MAP;
               end
            endcase
         end
         S_MAP: begin
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            case (cnt_ff[1:0])
               2'd0: cmd.mul_sel = MUL_QLO_D;
               2'd1: begin cmd.mul_sel = MUL_QHI_D; cmd.acc_load = 1'b1; end
               default: begin
                  cmd.map_step = 1'b1;
                  cnt_in = '0;
                  if (status.map_hit) begin
                     pbest_in = 1'b0;
                     pidx_in  = idx_ff;
                     prsn_in  = RSN_MAP;
                     state_in = S_DONE;
                  end else if (last) begin
                     pbest_in = 1'b1;
                     prsn_in  = RSN_FALLBACK;
                     state_in = S_DONE;
                  end else begin
                     idx_in = idx_ff + IDX_W'(1);
                  end
               end
            endcase
         end
         S_AGE: begin
            cmd.age_step = 1'b1;
            if (last) begin
               pbest_in = 1'b1;
               prsn_in  = RSN_AGEING;
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_DONE: begin
            if (!rv_ff || rsp_ready) begin
               rv_in    = 1'b1;
               rpath_in = pbest_ff ? status.best_idx : pidx_ff;
               rrsn_in  = prsn_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
         idx_ff   <= '0;
         n_ff     <= CNT_W'(1);
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         idx_ff   <= idx_in;
         n_ff     <= n_in;
         cnt_ff   <= cnt_in;
      end
   end

   // pending and output result
   always_ff @(posedge clock) begin
      pbest_ff <= pbest_in;
      pidx_ff  <= pidx_in;
      prsn_ff  <= prsn_in;
      rpath_ff <= rpath_in;
      rrsn_ff  <= rrsn_in;
   end

   assign rsp_valid  = rv_ff;
   assign rsp_path   = rpath_ff;
   assign rsp_reason = rrsn_ff;

endmodule
